// ===== hdl/imdb_pkg.sv =====
// Shared types and constants for the IQ magnitude DC-blocking unit.
package imdb_pkg;
	localparam int SAMPLE_FRAC = 24;
	localparam int EST_W = 40;

	typedef enum logic [2:0] {
		FMT_UC8 = 3'd0,
		FMT_SC16 = 3'd1,
		FMT_SC16Q11 = 3'd2,
		FMT_INT16 = 3'd3,
		FMT_OFF12 = 3'd4
	} fmt_t;

	typedef enum logic [1:0] {
		REG_FORMAT = 2'd0,
		REG_FEED = 2'd1,
		REG_KEEP = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic iir_lo;
		logic iir_hi;
		logic iir_sel_q;
		logic diff;
		logic square;
		logic sum;
		logic finish;
		logic accumulate;
	} dp_cmd_t;

	typedef struct packed {
		logic sqrt_done;
	} dp_sts_t;
endpackage

// ===== hdl/imdb_if.sv =====
// Valid/ready stream and configuration channel interfaces.
interface imdb_in_if;
	logic valid;
	logic ready;
	logic [15:0] sample_i;
	logic [15:0] sample_q;
	logic block_end;
	modport source (output valid, sample_i, sample_q, block_end, input ready);
	modport sink (input valid, sample_i, sample_q, block_end, output ready);
endinterface

interface imdb_out_if;
	logic valid;
	logic ready;
	logic [15:0] magnitude;
	logic block_last;
	logic [35:0] level_sum;
	logic [51:0] power_sum;
	logic [20:0] sample_count;
	modport source (output valid, magnitude, block_last, level_sum, power_sum,
		sample_count, input ready);
	modport sink (input valid, magnitude, block_last, level_sum, power_sum,
		sample_count, output ready);
endinterface

interface imdb_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/iq_magnitude_dc_block_unit.sv =====
// Top level: IQ magnitude with DC-blocking IIR and block statistics.
// Real and unused formats go from the load straight to finish and accumulate;
// IQ formats first pass the split IIR products, difference, square, sum and the bit-pair square root.
// One item is in flight at a time: a new transfer is taken in the idle state once the result
// register is free or being read. Asynchronous reset clears DC estimates, sums, count and
// registers to their reset values (keep coefficient 1.0).
module iq_magnitude_dc_block_unit #(
	parameter int MAX_BLOCK_SAMPLES = 1048576,
	parameter int COEFF_FRAC_BITS = 31
) (
	input logic clk,
	input logic arst_n,
	imdb_in_if.sink in_ch,
	imdb_out_if.source out_ch,
	imdb_cfg_if.sink cfg
);
	import imdb_pkg::*;

	logic [2:0] format_q;
	logic [31:0] feed_q, keep_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic is_iq;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_UC8;
			feed_q <= '0;
			keep_q <= 32'(64'd1 << COEFF_FRAC_BITS);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FORMAT: format_q <= cfg.data[2:0];
				REG_FEED: feed_q <= cfg.data;
				REG_KEEP: keep_q <= cfg.data;
				default: ;
			endcase
		end
	end

	imdb_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.is_iq, .cmd, .sts
	);

	imdb_datapath #(
		.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES), .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_dp (
		.clk, .arst_n,
		.sample_i(in_ch.sample_i), .sample_q(in_ch.sample_q), .block_end(in_ch.block_end),
		.sample_format(format_q), .dc_feed_coeff(feed_q), .dc_keep_coeff(keep_q),
		.cmd, .sts, .is_iq,
		.magnitude(out_ch.magnitude), .block_last(out_ch.block_last),
		.level_sum(out_ch.level_sum), .power_sum(out_ch.power_sum),
		.sample_count(out_ch.sample_count)
	);
endmodule

// ===== hdl/imdb_ctrl.sv =====
// Sequencing state machine for the IQ magnitude unit.
module imdb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input logic is_iq,
	output imdb_pkg::dp_cmd_t cmd,
	input imdb_pkg::dp_sts_t sts
);
	import imdb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_IIR_I, ST_IIR_IH, ST_IIR_Q, ST_IIR_QH, ST_DIFF, ST_SQ, ST_SUM, ST_SQRT,
		ST_FIN, ST_ACC
	} state_t;

	state_t state_q;
	logic out_valid_q;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.iir_lo = state_q == ST_IIR_I || state_q == ST_IIR_Q;
		cmd.iir_hi = state_q == ST_IIR_IH || state_q == ST_IIR_QH;
		cmd.iir_sel_q = state_q == ST_IIR_Q || state_q == ST_IIR_QH;
		cmd.diff = state_q == ST_DIFF;
		cmd.square = state_q == ST_SQ;
		cmd.sum = state_q == ST_SUM;
		cmd.finish = state_q == ST_FIN;
		cmd.accumulate = state_q == ST_ACC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= is_iq ? ST_IIR_I : ST_FIN;
				ST_IIR_I: state_q <= ST_IIR_IH;
				ST_IIR_IH: state_q <= ST_IIR_Q;
				ST_IIR_Q: state_q <= ST_IIR_QH;
				ST_IIR_QH: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_SQRT;
				ST_SQRT: if (sts.sqrt_done) state_q <= ST_FIN;
				ST_FIN: state_q <= ST_ACC;
				ST_ACC: begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("accept while busy");
	a_out_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |=> out_valid_q) else $error("result lost");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q) else $error("result dropped");
endmodule

// ===== hdl/imdb_datapath.sv =====
// Normalization, DC-blocking IIR, square root and block sums.
module imdb_datapath #(
	parameter int MAX_BLOCK_SAMPLES = 1048576,
	parameter int COEFF_FRAC_BITS = 31
) (
	input logic clk,
	input logic arst_n,
	input logic [15:0] sample_i,
	input logic [15:0] sample_q,
	input logic block_end,
	input logic [2:0] sample_format,
	input logic [31:0] dc_feed_coeff,
	input logic [31:0] dc_keep_coeff,
	input imdb_pkg::dp_cmd_t cmd,
	output imdb_pkg::dp_sts_t sts,
	output logic is_iq,
	output logic [15:0] magnitude,
	output logic block_last,
	output logic [35:0] level_sum,
	output logic [51:0] power_sum,
	output logic [20:0] sample_count
);
	import imdb_pkg::*;

	localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
	localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
	localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

	logic [2:0] fmt_q;
	logic [15:0] wi_q, wq_q;
	logic end_q;
	logic signed [EST_W-1:0] xi_q, xq_q, zi_q, zq_q;
	logic [24:0] yi_q, yq_q;
	logic big_q;
	logic [49:0] sqi_q, sqq_q;
	logic [63:0] rem_q, root_q, bit_q;
	logic [15:0] mag_q;
	logic [35:0] lacc_q;
	logic [51:0] pacc_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [57:0] plo_q;

	// 2^24 / 255 = 65793 + 1/255, so the rounded quotient needs one extra unit
	// exactly when the odd level |d| is at least 128.
	function automatic logic signed [EST_W-1:0] norm(input logic [2:0] f, input logic [15:0] w);
		logic signed [9:0] d;
		logic [7:0] ad;
		logic [31:0] q;
		d = $signed({1'b0, w[7:0], 1'b0}) - 10'sd255;
		ad = d < 0 ? 8'(-d) : d[7:0];
		q = 32'(ad) * 32'd65793 + {31'd0, ad[7]};
		case (f)
			FMT_UC8: norm = d < 0 ? -$signed({8'd0, q}) : $signed({8'd0, q});
			FMT_SC16: norm = EST_W'($signed(w)) <<< 9;
			FMT_SC16Q11: norm = EST_W'($signed(w)) <<< 13;
			default: norm = '0;
		endcase
	endfunction

	logic signed [EST_W:0] di, dq;
	logic [EST_W:0] ai, aq;
	logic [11:0] rv;
	logic [16:0] sabs;
	logic [15:0] rt;
	logic [11:0] rsum;
	logic [15:0] rmag;
	logic [47:0] rnd;
	logic [CNT_W-1:0] cnt_n;
	logic signed [EST_W-1:0] iir_x, iir_z, iir_new;
	logic signed [57:0] prod_lo, prod_hi, iir_acc, iir_r;

	assign is_iq = sample_format == FMT_UC8 || sample_format == FMT_SC16
		|| sample_format == FMT_SC16Q11;
	assign di = (EST_W+1)'(xi_q) - (EST_W+1)'(zi_q);
	assign dq = (EST_W+1)'(xq_q) - (EST_W+1)'(zq_q);
	assign ai = di[EST_W] ? -di : di;
	assign aq = dq[EST_W] ? -dq : dq;
	assign sts.sqrt_done = bit_q == 64'd0;
	assign cnt_n = cnt_q + 1'b1;

	// The IIR product is split on the 16-bit halves of the coefficients: the low
	// half is registered first and folded into the high half in the next cycle.
	always_comb begin
		iir_x = cmd.iir_sel_q ? xq_q : xi_q;
		iir_z = cmd.iir_sel_q ? zq_q : zi_q;
		prod_lo = 58'(iir_x) * 58'($signed({1'b0, dc_feed_coeff[15:0]}))
			+ 58'(iir_z) * 58'($signed({1'b0, dc_keep_coeff[15:0]}));
		prod_hi = 58'(iir_x) * 58'($signed({1'b0, dc_feed_coeff[31:16]}))
			+ 58'(iir_z) * 58'($signed({1'b0, dc_keep_coeff[31:16]}));
		iir_acc = prod_hi + (plo_q >>> 16);
		iir_r = iir_acc >>> (COEFF_FRAC_BITS - 16);
		if (iir_r > 58'(EST_MAX)) iir_new = EST_MAX;
		else if (iir_r < 58'(EST_MIN)) iir_new = EST_MIN;
		else iir_new = iir_r[EST_W-1:0];
	end

	always_comb begin
		sabs = wi_q[15] ? 17'(-$signed(wi_q)) : {1'b0, wi_q};
		if (fmt_q == FMT_INT16) rv = sabs[16:4] > 13'd2047 ? 12'd2047 : sabs[15:4];
		else begin
			sabs = 17'({1'b0, wi_q}) - 17'd2048;
			sabs = sabs[16] ? -sabs : sabs;
			rv = sabs > 17'd2047 ? 12'd2047 : sabs[11:0];
		end
		// 65535 = 32 * 2047 + 31, and a division by 2047 = 2^11 - 1 needs at most
		// one correction after the shift.
		rt = 16'(rv) * 16'd31 + 16'd1023;
		rsum = {1'b0, rt[10:0]} + 12'(rt[15:11]);
		rmag = {rv[10:0], 5'd0} + 16'(rt[15:11]) + 16'(rsum >= 12'd2047);
		rnd = 48'(root_q[30:0]) * 48'd65535 + 48'd1073741824;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= '0;
			wi_q <= '0;
			wq_q <= '0;
			end_q <= 1'b0;
			xi_q <= '0;
			xq_q <= '0;
			zi_q <= '0;
			zq_q <= '0;
			plo_q <= '0;
			yi_q <= '0;
			yq_q <= '0;
			big_q <= 1'b0;
			sqi_q <= '0;
			sqq_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			mag_q <= '0;
			lacc_q <= '0;
			pacc_q <= '0;
			cnt_q <= '0;
			bit_q <= '0;
			magnitude <= '0;
			block_last <= 1'b0;
			level_sum <= '0;
			power_sum <= '0;
			sample_count <= '0;
		end else begin
			if (cmd.load) begin
				fmt_q <= sample_format;
				wi_q <= sample_i;
				wq_q <= sample_q;
				end_q <= block_end;
				xi_q <= norm(sample_format, sample_i);
				xq_q <= norm(sample_format, sample_q);
			end
			if (cmd.iir_lo) plo_q <= prod_lo;
			if (cmd.iir_hi) begin
				if (cmd.iir_sel_q) zq_q <= iir_new;
				else zi_q <= iir_new;
			end
			if (cmd.diff) begin
				big_q <= ai >= (EST_W+1)'(1 << SAMPLE_FRAC) || aq >= (EST_W+1)'(1 << SAMPLE_FRAC);
				yi_q <= ai[24:0];
				yq_q <= aq[24:0];
			end
			if (cmd.square) begin
				sqi_q <= 50'(yi_q) * 50'(yi_q);
				sqq_q <= 50'(yq_q) * 50'(yq_q);
			end
			if (cmd.sum) begin
				rem_q <= 64'(sqi_q + sqq_q) << 14;
				big_q <= big_q || (sqi_q + sqq_q) >= (50'd1 << 48);
				root_q <= '0;
				bit_q <= 64'd1 << 62;
			end else if (bit_q != 0) begin
				if (rem_q >= root_q + bit_q) begin
					rem_q <= rem_q - (root_q + bit_q);
					root_q <= (root_q >> 1) + bit_q;
				end else root_q <= root_q >> 1;
				bit_q <= bit_q >> 2;
			end
			if (cmd.finish) begin
				if (fmt_q == FMT_UC8 || fmt_q == FMT_SC16 || fmt_q == FMT_SC16Q11)
					mag_q <= big_q ? 16'hFFFF : rnd[46:31];
				else if (fmt_q == FMT_INT16 || fmt_q == FMT_OFF12) mag_q <= rmag;
				else mag_q <= '0;
			end
			if (cmd.accumulate) begin
				magnitude <= mag_q;
				if (end_q || cnt_n >= CNT_W'(MAX_BLOCK_SAMPLES)) begin
					block_last <= 1'b1;
					level_sum <= lacc_q + 36'(mag_q);
					power_sum <= pacc_q + 52'(32'(mag_q) * 32'(mag_q));
					sample_count <= 21'(cnt_n);
					lacc_q <= '0;
					pacc_q <= '0;
					cnt_q <= '0;
				end else begin
					block_last <= 1'b0;
					level_sum <= '0;
					power_sum <= '0;
					sample_count <= '0;
					lacc_q <= lacc_q + 36'(mag_q);
					pacc_q <= pacc_q + 52'(32'(mag_q) * 32'(mag_q));
					cnt_q <= cnt_n;
				end
			end
		end
	end
endmodule

// ===== tb/sv/iq_magnitude_dc_block_unit_tb.sv =====
// Self-checking testbench for the IQ magnitude DC-blocking unit with random stimulus and stalls.
`timescale 1ns / 1ps
module iq_magnitude_dc_block_unit_tb;
	import imdb_pkg::*;

	typedef struct packed {
		logic [15:0] wi;
		logic [15:0] wq;
		logic fin;
	} sample_t;

	typedef struct packed {
		logic [15:0] mag;
		logic last;
		logic [35:0] lsum;
		logic [51:0] psum;
		logic [20:0] cnt;
	} mag_result_t;

	localparam int MAX_BLOCK = 1048576;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;

	imdb_in_if in_ch();
	imdb_out_if out_ch();
	imdb_cfg_if cfg();

	iq_magnitude_dc_block_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg(cfg.sink)
	);

	sample_t pending_samples[$];
	mag_result_t expected_mags[$];

	logic [2:0] fmt_reg;
	logic [31:0] feed_reg;
	logic [31:0] keep_reg;
	longint est_i, est_q;
	logic [35:0] level_acc;
	logic [51:0] power_acc;
	int unsigned blk_count;

	int send_idle_pct;
	int recv_stall_pct;
	bit recv_hold;
	bit in_fired;
	int hold_cycles;
	int errors;
	int results_seen;
	int idle_cycles;
	int blocks_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint dc_track(longint x, longint z);
		longint ah, al, bh, bl, hi, lo, r;
		ah = longint'(feed_reg[31:16]);
		al = longint'(feed_reg[15:0]);
		bh = longint'(keep_reg[31:16]);
		bl = longint'(keep_reg[15:0]);
		hi = x * ah + z * bh;
		lo = x * al + z * bl;
		r = floor_shr(hi + floor_shr(lo, 16), 15);
		if (r > 64'sd549755813887) r = 64'sd549755813887;
		if (r < -64'sd549755813888) r = -64'sd549755813888;
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint norm_byte(logic [15:0] w);
		longint d, q;
		longint unsigned m;
		d = 2 * longint'(w[7:0]) - 255;
		m = longint'(d < 0 ? -d : d) << SAMPLE_FRAC;
		q = longint'((m + 127) / 255);
		return d < 0 ? -q : q;
	endfunction

	function automatic logic [15:0] iq_mag(longint xi, longint xq);
		longint yi, yq;
		longint unsigned m, s;
		est_i = dc_track(xi, est_i);
		est_q = dc_track(xq, est_q);
		yi = xi - est_i;
		yq = xq - est_q;
		if (yi < 0) yi = -yi;
		if (yq < 0) yq = -yq;
		if (yi >= (64'sd1 << SAMPLE_FRAC) || yq >= (64'sd1 << SAMPLE_FRAC)) return 16'hFFFF;
		m = longint'(yi * yi) + longint'(yq * yq);
		if (m >= (64'd1 << 48)) return 16'hFFFF;
		s = int_sqrt(m << 14);
		return 16'((65535 * s + (64'd1 << 30)) >> 31);
	endfunction

	function automatic logic [15:0] level_mag(longint unsigned v);
		if (v > 2047) v = 2047;
		return 16'((65535 * v + 1023) / 2047);
	endfunction

	function automatic mag_result_t predict_magnitude(sample_t s);
		mag_result_t r;
		logic [15:0] mag;
		longint v;
		case (fmt_reg)
			FMT_UC8: mag = iq_mag(norm_byte(s.wi), norm_byte(s.wq));
			FMT_SC16: mag = iq_mag(longint'($signed(s.wi)) * 512,
				longint'($signed(s.wq)) * 512);
			FMT_SC16Q11: mag = iq_mag(longint'($signed(s.wi)) * 8192,
				longint'($signed(s.wq)) * 8192);
			FMT_INT16: begin
				v = longint'($signed(s.wi));
				if (v < 0) v = -v;
				mag = level_mag(v >> 4);
			end
			FMT_OFF12: begin
				v = longint'(s.wi) - 2048;
				if (v < 0) v = -v;
				mag = level_mag(v);
			end
			default: mag = 16'd0;
		endcase
		level_acc = level_acc + 36'(mag);
		power_acc = power_acc + 52'(longint'(mag) * longint'(mag));
		blk_count++;
		r = '0;
		r.mag = mag;
		if (s.fin || blk_count >= MAX_BLOCK) begin
			r.last = 1'b1;
			r.lsum = level_acc;
			r.psum = power_acc;
			r.cnt = 21'(blk_count);
			level_acc = '0;
			power_acc = '0;
			blk_count = 0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
	endtask

	// Input transfers are taken at the rising edge and predicted in order.
	always @(posedge clk) begin
		in_fired = arst_n && in_ch.valid && in_ch.ready;
		if (in_fired)
			expected_mags.push_back(predict_magnitude(pending_samples.pop_front()));
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Driver: an offered sample is held until its transfer.
	sample_t cur;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !in_fired) begin
			in_ch.valid <= 1'b1;
		end else if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			cur = pending_samples[0];
			in_ch.valid <= 1'b1;
			in_ch.sample_i <= cur.wi;
			in_ch.sample_q <= cur.wq;
			in_ch.block_end <= cur.fin;
		end else begin
			in_ch.valid <= 1'b0;
		end
		out_ch.ready <= arst_n && !recv_hold && $urandom_range(99) >= recv_stall_pct;
	end

	// Monitor: checks each result transfer against the oldest prediction.
	always @(posedge clk) begin
		mag_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_mags.size() == 0) begin
				errors++;
				$display("MISMATCH result %0d with nothing expected", results_seen);
			end else begin
				want = expected_mags.pop_front();
				if (out_ch.magnitude !== want.mag)
					report_mismatch("magnitude", out_ch.magnitude, want.mag);
				if (out_ch.block_last !== want.last)
					report_mismatch("block_last", out_ch.block_last, want.last);
				if (out_ch.level_sum !== want.lsum)
					report_mismatch("level_sum", out_ch.level_sum, want.lsum);
				if (out_ch.power_sum !== want.psum)
					report_mismatch("power_sum", out_ch.power_sum, want.psum);
				if (out_ch.sample_count !== want.cnt)
					report_mismatch("sample_count", out_ch.sample_count, want.cnt);
				if (want.last) blocks_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("Watchdog expired with %0d results outstanding", expected_mags.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_FORMAT: fmt_reg = val[2:0];
			REG_FEED: feed_reg = val;
			REG_KEEP: keep_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || expected_mags.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic push_sample(logic [15:0] wi, logic [15:0] wq, logic fin);
		sample_t s;
		s.wi = wi;
		s.wq = wq;
		s.fin = fin;
		pending_samples.push_back(s);
	endtask

	function automatic logic [15:0] rand_word(logic [2:0] f);
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'((f == FMT_SC16Q11) ? $urandom_range(2047) : $urandom_range(255));
			3: return 16'(-$urandom_range(2047));
			4: return 16'(2048 + $urandom_range(4095) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(int count, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int k = 0; k < count; k++)
			push_sample(rand_word(fmt_reg), rand_word(fmt_reg), $urandom_range(15) == 0);
		drain();
	endtask

	initial begin
		logic [31:0] feeds[4];
		logic [31:0] keeps[4];
		in_ch.valid = 1'b0;
		in_ch.sample_i = '0;
		in_ch.sample_q = '0;
		in_ch.block_end = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_FORMAT;
		cfg.data = '0;
		fmt_reg = FMT_UC8;
		feed_reg = '0;
		keep_reg = 32'h8000_0000;
		est_i = 0;
		est_q = 0;
		level_acc = '0;
		power_acc = '0;
		blk_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b0;
		errors = 0;
		results_seen = 0;
		blocks_seen = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n = 1'b1;

		// Directed: field extremes in every format, including unused codes.
		for (int f = 0; f < 8; f++) begin
			write_reg(REG_FORMAT, 32'(f));
			push_sample(16'h0000, 16'hFFFF, 1'b0);
			push_sample(16'h8000, 16'h7FFF, 1'b0);
			push_sample(16'h0800, 16'h00FF, 1'b1);
			drain();
		end
		write_reg(REG_FEED, 32'h8000_0000);
		write_reg(REG_KEEP, 32'hFFFF_FFFF);
		write_reg(REG_FORMAT, 32'(FMT_SC16Q11));
		push_sample(16'h7FFF, 16'h7FFF, 1'b0);
		push_sample(16'h0001, 16'hFFFF, 1'b1);
		drain();

		feeds = '{32'h0, 32'h0100_0000, 32'h8000_0000, 32'hFFFF_FFFF};
		keeps = '{32'h8000_0000, 32'h7F00_0000, 32'h0, 32'hFFFF_FFFF};
		for (int p = 0; p < 10; p++) begin
			write_reg(REG_FORMAT, 32'(p < 8 ? p % 5 : $urandom_range(7)));
			write_reg(REG_FEED, feeds[p % 4]);
			write_reg(REG_KEEP, keeps[(p / 2) % 4]);
			case (p % 4)
				0: random_phase(70, 0, 0);
				1: random_phase(70, 68, 0);
				2: random_phase(70, 0, 68);
				default: random_phase(70, 20, 20);
			endcase
		end

		// Long receiver hold-off while the sender keeps offering samples.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int k = 0; k < 30; k++) push_sample(16'($urandom), 16'($urandom), k == 29);
		recv_hold = 1'b1;
		hold_cycles = 0;
		while (hold_cycles < 400) begin
			@(posedge clk);
			hold_cycles++;
		end
		recv_hold = 1'b0;
		drain();

		$display("Covered %0d results in %0d blocks across all sample formats,",
			results_seen, blocks_seen);
		$display("coefficient extremes and sender/receiver stall mixes.");
		if (errors == 0 && expected_mags.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== iq_magnitude_dc_block_unit.f =====
hdl/imdb_pkg.sv
hdl/imdb_if.sv
hdl/imdb_ctrl.sv
hdl/imdb_datapath.sv
hdl/iq_magnitude_dc_block_unit.sv
tb/sv/iq_magnitude_dc_block_unit_tb.sv
